// ===== sv/aec_pkg.sv =====
// Shared types and constants of the actuator end-stop calibrator.
`timescale 1ns / 1ps
`default_nettype none

package aec_pkg;

  localparam int WIN_LEN   = 10;
  localparam int SAMPLE_W  = 10;
  localparam int SPEED_W   = 8;
  localparam int SLOT_W    = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
  localparam int SUM_W     = $clog2(((2 ** SAMPLE_W) - 1) * WIN_LEN + 1);

  // Division of the window sum by WIN_LEN as a multiply by a rounded-up
  // reciprocal; exact for every sum below 2**SUM_W.
  localparam int DIV_SH    = SUM_W + $clog2(WIN_LEN);
  localparam int DIV_MUL   = (2 ** DIV_SH) / WIN_LEN + 1;
  localparam int DIV_MUL_W = DIV_SH + 1;
  localparam int PROD_W    = SUM_W + DIV_MUL_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [SPEED_W-1:0]  CLOSING_RST = 8'hC4;  // -60 percent
  localparam logic [SPEED_W-1:0]  OPENING_RST = 8'h28;  // +40 percent
  localparam logic [SAMPLE_W-1:0] THRESH_RST  = 10'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLOSING_SPEED = 2'd0,
    REG_OPENING_SPEED = 2'd1,
    REG_THRESHOLD     = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_CLOSING = 2'd0,
    PH_OPENING = 2'd1,
    PH_DONE    = 2'd2
  } phase_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] closing_speed;
    logic signed [SPEED_W-1:0] opening_speed;
    logic [SAMPLE_W-1:0]       threshold;
  } cfg_t;

  // Write side of the window store.
  typedef struct packed {
    logic                push;
    logic                clear;
    logic [SLOT_W-1:0]   slot;
    logic [SAMPLE_W-1:0] value;
  } win_wr_t;

  // Registered read result of the window store.
  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] value;
  } win_rd_t;

endpackage

`default_nettype wire

// ===== sv/aec_window_store.sv =====
// Window ring memory with per-entry valid bits and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module aec_window_store (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          rd_en,
  input  wire logic [aec_pkg::SLOT_W-1:0]    rd_slot,
  input  wire aec_pkg::win_wr_t              wr,
  output aec_pkg::win_rd_t                   rd
);

  logic [aec_pkg::SAMPLE_W-1:0] mem [aec_pkg::WIN_LEN];
  logic [aec_pkg::WIN_LEN-1:0]  valid;

  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem[wr.slot] <= wr.value;
    end
  end

  // A clear drops every entry at once; an entry that is not valid reads as zero.
  always_ff @(posedge clk) begin
    if (rst || wr.clear) begin
      valid <= '0;
    end else if (wr.push) begin
      valid[wr.slot] <= 1'b1;
    end
  end

  // The read that happens at the same edge as a clear must see the cleared window.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd.value <= mem[rd_slot];
      rd.valid <= valid[rd_slot] && !wr.clear;
    end
  end

endmodule

`default_nettype wire

// ===== sv/aec_stop_tracker.sv =====
// Running sum, average, stability test and seek-phase sequencing.
`timescale 1ns / 1ps
`default_nettype none

module aec_stop_tracker (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                fire,
  input  wire logic                                restart,
  input  wire logic [aec_pkg::SAMPLE_W-1:0]        sample,
  input  wire logic [aec_pkg::SLOT_W-1:0]          slot,
  input  wire aec_pkg::win_rd_t                    rd,
  input  wire aec_pkg::cfg_t                       cfg,
  output aec_pkg::win_wr_t                         wr,
  output logic signed [aec_pkg::SPEED_W-1:0]       motor_drive,
  output logic [1:0]                               phase_out,
  output logic [aec_pkg::SAMPLE_W-1:0]             closed_position,
  output logic [aec_pkg::SAMPLE_W-1:0]             open_position,
  output logic                                     limit_found
);

  aec_pkg::phase_t              phase, phase_next;
  logic [aec_pkg::SUM_W-1:0]    sum, sum_next, sum_new;
  logic [aec_pkg::SAMPLE_W-1:0] closed_stop, closed_stop_next;
  logic [aec_pkg::SAMPLE_W-1:0] open_stop, open_stop_next;
  logic [aec_pkg::SAMPLE_W-1:0] old_value, avg, diff;
  logic [aec_pkg::PROD_W-1:0]   prod;
  logic                         seeking, stable;

  assign old_value = rd.valid ? rd.value : '0;
  assign sum_new   = sum - aec_pkg::SUM_W'(old_value) + aec_pkg::SUM_W'(sample);
  assign prod      = aec_pkg::PROD_W'(sum_new) * aec_pkg::PROD_W'(aec_pkg::DIV_MUL);
  assign avg       = prod[aec_pkg::DIV_SH +: aec_pkg::SAMPLE_W];
  assign diff      = (sample >= avg) ? (sample - avg) : (avg - sample);
  assign seeking   = !restart && (phase == aec_pkg::PH_CLOSING || phase == aec_pkg::PH_OPENING);
  assign stable    = seeking && (diff < cfg.threshold);

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (restart) begin
      phase_next = aec_pkg::PH_CLOSING;
    end else if (stable) begin
      unique case (phase)
        aec_pkg::PH_CLOSING: phase_next = aec_pkg::PH_OPENING;
        aec_pkg::PH_OPENING: phase_next = aec_pkg::PH_DONE;
        default:             phase_next = phase;
      endcase
    end
  end

  // Datapath updates and results of the current word.
  always_comb begin
    sum_next         = sum;
    closed_stop_next = closed_stop;
    open_stop_next   = open_stop;
    wr.push          = fire && seeking;
    wr.clear         = fire && (restart || stable);
    wr.slot          = slot;
    wr.value         = sample;
    if (restart) begin
      sum_next         = '0;
      closed_stop_next = '0;
      open_stop_next   = '0;
    end else if (stable) begin
      sum_next = '0;
      if (phase == aec_pkg::PH_CLOSING) begin
        closed_stop_next = avg;
      end else begin
        open_stop_next = avg;
      end
    end else if (seeking) begin
      sum_next = sum_new;
    end

    unique case (phase_next)
      aec_pkg::PH_CLOSING: motor_drive = cfg.closing_speed;
      aec_pkg::PH_OPENING: motor_drive = cfg.opening_speed;
      default:             motor_drive = '0;
    endcase
    phase_out       = phase_next;
    closed_position = closed_stop_next;
    open_position   = open_stop_next;
    limit_found     = stable;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= aec_pkg::PH_CLOSING;
      sum         <= '0;
      closed_stop <= '0;
      open_stop   <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      sum         <= sum_next;
      closed_stop <= closed_stop_next;
      open_stop   <= open_stop_next;
    end
  end

  a_clear_zeroes_sum: assert property (@(posedge clk) disable iff (rst)
    wr.clear |=> (sum == '0))
    else $error("window sum not cleared after a window clear");

  a_found_advances: assert property (@(posedge clk) disable iff (rst)
    (fire && stable) |=> (phase != $past(phase)))
    else $error("stop recorded without a phase change");

  a_restart_state: assert property (@(posedge clk) disable iff (rst)
    (fire && restart) |=> (phase == aec_pkg::PH_CLOSING && closed_stop == '0 && open_stop == '0))
    else $error("restart did not return to the closing phase");

endmodule

`default_nettype wire

// ===== sv/actuator_endstop_calibrator_top.sv =====
// Top level of the actuator end-stop calibrator: stream ports, config and pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Pipeline: the edge that accepts a word reads the window memory into the read
// stage, and the edge that evaluates it registers the result on m_axis.
// Throughput: one word per cycle; the only stall is a full output register.
// Reset (rst, synchronous): phase closing, stops and sum zero, every window entry
// invalid at once through its valid bit, speeds -60 and +40, threshold 2.
module actuator_endstop_calibrator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [9:0] sample, [15:10] zero
  input  wire logic        s_axis_tuser,   // [0] restart
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [7:0] motor_drive, [9:8] phase,
                                           // [19:10] closed_position,
                                           // [29:20] open_position,
                                           // [30] limit_found, [31] zero
  input  wire logic                               cfg_we,
  input  wire logic [aec_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [aec_pkg::CFG_DATA_W-1:0]     cfg_data
);

  aec_pkg::cfg_t cfg;

  // Configuration registers; indexes without a register are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.closing_speed <= aec_pkg::CLOSING_RST;
      cfg.opening_speed <= aec_pkg::OPENING_RST;
      cfg.threshold     <= aec_pkg::THRESH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aec_pkg::REG_CLOSING_SPEED: cfg.closing_speed <= cfg_data[aec_pkg::SPEED_W-1:0];
        aec_pkg::REG_OPENING_SPEED: cfg.opening_speed <= cfg_data[aec_pkg::SPEED_W-1:0];
        aec_pkg::REG_THRESHOLD:     cfg.threshold     <= cfg_data[aec_pkg::SAMPLE_W-1:0];
        default:                    cfg.threshold     <= cfg.threshold;
      endcase
    end
  end

  // The ring slot advances on every accepted word. After a clear every entry
  // reads as zero, so the ring may restart from any slot; this keeps the read
  // address independent of the word still being evaluated.
  logic [aec_pkg::SLOT_W-1:0]   slot;
  logic                         in_fire, eval_fire;
  logic                         a_valid, a_restart;
  logic [aec_pkg::SAMPLE_W-1:0] a_sample;
  logic [aec_pkg::SLOT_W-1:0]   a_slot;

  assign eval_fire     = a_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !a_valid || eval_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (in_fire) begin
      slot <= (slot == aec_pkg::SLOT_W'(aec_pkg::WIN_LEN - 1)) ? '0 : slot + 1'b1;
    end
  end

  // Read stage: holds the word while the memory delivers the entry it replaces.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_fire) begin
      a_valid <= 1'b1;
    end else if (eval_fire) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_restart <= s_axis_tuser;
      a_sample  <= s_axis_tdata[aec_pkg::SAMPLE_W-1:0];
      a_slot    <= slot;
    end
  end

  aec_pkg::win_wr_t win_wr;
  aec_pkg::win_rd_t win_rd;

  aec_window_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_fire),
    .rd_slot (slot),
    .wr      (win_wr),
    .rd      (win_rd)
  );

  logic signed [aec_pkg::SPEED_W-1:0] res_drive;
  logic [1:0]                         res_phase;
  logic [aec_pkg::SAMPLE_W-1:0]       res_closed, res_open;
  logic                               res_found;

  aec_stop_tracker u_tracker (
    .clk             (clk),
    .rst             (rst),
    .fire            (eval_fire),
    .restart         (a_restart),
    .sample          (a_sample),
    .slot            (a_slot),
    .rd              (win_rd),
    .cfg             (cfg),
    .wr              (win_wr),
    .motor_drive     (res_drive),
    .phase_out       (res_phase),
    .closed_position (res_closed),
    .open_position   (res_open),
    .limit_found     (res_found)
  );

  // Output register: the result word waits here while the next word is read.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (eval_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_fire) begin
      m_axis_tdata <= {1'b0, res_found, res_open, res_closed, res_phase, res_drive};
    end
  end

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (a_valid && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while the pipeline is stalled");

  a_found_has_phase: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[30])
      |-> (m_axis_tdata[9:8] == aec_pkg::PH_OPENING || m_axis_tdata[9:8] == aec_pkg::PH_DONE))
    else $error("stop reported while still closing");

  a_done_no_drive: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[9:8] == aec_pkg::PH_DONE) |-> (m_axis_tdata[7:0] == '0))
    else $error("motor driven after calibration finished");

endmodule

`default_nettype wire
